// File: rtl/slfs_pkg.sv
// Shared types and constants for the single-wire LED frame sender.
// No dependencies; imported by every module of the block.
`default_nettype none

package slfs_pkg;

  localparam int unsigned SlotW     = 8;
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned WordW     = 32;
  localparam int unsigned CountW    = 6;

  localparam logic [7:0] HeaderByte = 8'h3A;

  // Register indexes on the configuration port
  localparam logic [CfgAddrW-1:0] CfgBitSlots   = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgSecondSlot = 2'd1;
  localparam logic [CfgAddrW-1:0] CfgEosSlots   = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgLatchSlots = 2'd3;

  localparam logic [SlotW-1:0] BitSlotsRst   = 8'd7;
  localparam logic [SlotW-1:0] SecondSlotRst = 8'd2;
  localparam logic [SlotW-1:0] EosSlotsRst   = 8'd32;
  localparam logic [SlotW-1:0] LatchSlotsRst = 8'd80;

  // Input item kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindTick  = 1'b1;

  typedef struct packed {
    logic [SlotW-1:0] bit_slots;
    logic [SlotW-1:0] second_pulse_slot;
    logic [SlotW-1:0] eos_slots;
    logic [SlotW-1:0] latch_slots;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/slfs_cfg_regs.sv
// Configuration register bank of the single-wire LED frame sender.
// Depends on slfs_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module slfs_cfg_regs
  import slfs_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [SlotW-1:0]    cfg_wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_slots         <= BitSlotsRst;
      cfg_q.second_pulse_slot <= SecondSlotRst;
      cfg_q.eos_slots         <= EosSlotsRst;
      cfg_q.latch_slots       <= LatchSlotsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgBitSlots:   cfg_q.bit_slots         <= cfg_wdata_i;
        CfgSecondSlot: cfg_q.second_pulse_slot <= cfg_wdata_i;
        CfgEosSlots:   cfg_q.eos_slots         <= cfg_wdata_i;
        CfgLatchSlots: cfg_q.latch_slots       <= cfg_wdata_i;
        default:       cfg_q                   <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/slfs_engine.sv
// Frame state and per-item waveform logic of the single-wire LED sender.
// Depends on slfs_pkg; state advances once for each item stepped through.
`default_nettype none

module slfs_engine
  import slfs_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhData  = 2'd1,
    PhEos   = 2'd2,
    PhLatch = 2'd3
  } phase_e;

  localparam logic [CountW-1:0] FrameBitsCnt = CountW'(FRAME_BITS % 64);

  phase_e             phase_q, phase_d;
  logic [WordW-1:0]   shift_q, shift_d;
  logic [CountW-1:0]  bits_q, bits_d;
  logic [SlotW-1:0]   slot_q, slot_d;

  logic [SlotW-1:0]   slot_inc;
  logic [SlotW-1:0]   period_len;
  logic               period_end;
  logic [CountW-1:0]  bits_dec;
  res_t               res;

  assign slot_inc = slot_q + SlotW'(1);
  assign bits_dec = bits_q - CountW'(1);

  always_comb begin
    unique case (phase_q)
      PhEos:   period_len = cfg_i.eos_slots;
      PhLatch: period_len = cfg_i.latch_slots;
      default: period_len = cfg_i.bit_slots;
    endcase
  end

  // A zero length closes the period on every tick, as does wrap-around.
  assign period_end = (slot_inc >= period_len) || (slot_inc == '0);

  always_comb begin
    phase_d = phase_q;
    shift_d = shift_q;
    bits_d  = bits_q;
    slot_d  = slot_q;
    res     = '0;

    if (item_i.kind == KindStart) begin
      res.busy_res = 1'b1;
      if (phase_q == PhIdle) begin
        shift_d      = {HeaderByte, item_i.red, item_i.green, item_i.blue};
        bits_d       = FrameBitsCnt;
        slot_d       = '0;
        phase_d      = (FrameBitsCnt == '0) ? PhEos : PhData;
        res.accepted = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhData: begin
          res.busy_res   = 1'b1;
          res.line_level = (slot_q == '0) ||
                           (shift_q[WordW-1] && (slot_q == cfg_i.second_pulse_slot));
          slot_d = period_end ? '0 : slot_inc;
          if (period_end) begin
            shift_d = {shift_q[WordW-2:0], 1'b0};
            bits_d  = bits_dec;
            if (bits_dec == '0) begin
              phase_d = PhEos;
            end
          end
        end
        PhEos: begin
          res.busy_res = 1'b1;
          slot_d = period_end ? '0 : slot_inc;
          if (period_end) begin
            phase_d = PhLatch;
          end
        end
        PhLatch: begin
          res.busy_res = 1'b1;
          slot_d = period_end ? '0 : slot_inc;
          if (period_end) begin
            phase_d        = PhIdle;
            res.frame_done = 1'b1;
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      shift_q <= '0;
      bits_q  <= '0;
      slot_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      slot_q  <= slot_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// File: rtl/single_wire_led_frame_sender.sv
// Top level of the single-wire LED frame sender: input register, engine, result register.
// Depends on slfs_pkg, slfs_cfg_regs and slfs_engine.
//
//   channel   direction  payload
//   s_axis    in         tuser = kind, tdata = red, green, blue
//   m_axis    out        tdata = line_level, busy_res, accepted; tlast = frame_done
//   cfg       in         cfg_we_i, cfg_addr_i (register index), cfg_wdata_i
//
// One item per clock cycle sustained while m_axis does not stall; each item passes
// through the input register and then the result register.
// Reset clears the frame state to idle and loads the register defaults.
// A stall on m_axis holds both registers; the input side keeps taking a
// transfer while the input register is empty or moves on in the same cycle.
`default_nettype none

module single_wire_led_frame_sender
  import slfs_pkg::*;
#(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // slave side
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  wire logic                s_axis_tuser,   // kind
  // master side
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output      logic [7:0]          m_axis_tdata,   // line_level[0], busy_res[1], accepted[2]
  output      logic                m_axis_tlast,   // frame_done
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgAddrW-1:0] cfg_addr_i,
  input  wire logic [SlotW-1:0]    cfg_wdata_i
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_valid_q;
  res_t  res;
  res_t  res_q;
  logic  out_valid_q;
  logic  advance;

  slfs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Move the held item through the engine when the result register frees up.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.kind  <= s_axis_tuser;
      item_q.red   <= s_axis_tdata[7:0];
      item_q.green <= s_axis_tdata[15:8];
      item_q.blue  <= s_axis_tdata[23:16];
    end
  end

  slfs_engine #(
    .FRAME_BITS(FRAME_BITS)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(item_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, res_q.accepted, res_q.busy_res, res_q.line_level};
  assign m_axis_tlast  = res_q.frame_done;

endmodule

`default_nettype wire

// File: tb/sv/tb_single_wire_led_frame_sender.sv
// Self-checking bench for single_wire_led_frame_sender: random start/tick stream, random
// back-pressure and register settings, per-item prediction of the line waveform.
// Depends on slfs_pkg and the RTL of the block.
module tb_single_wire_led_frame_sender;
  import slfs_pkg::*;

  localparam int unsigned FrameBits  = 32;
  localparam int unsigned HoldCycles = 40;

  typedef enum logic [1:0] {LineIdle, LineData, LineEos, LineLatch} line_phase_e;

  // Tracks the frame engine and queues the expected result of every transfer.
  class frame_scoreboard;
    int unsigned       frame_bits;
    logic [SlotW-1:0]  bit_slots, second_slot, eos_slots, latch_slots;
    logic [WordW-1:0]  shift_word;
    logic [CountW-1:0] bits_left;
    logic [SlotW-1:0]  slot_cnt;
    line_phase_e       line_phase;
    res_t              line_results_q[$];
    int                errors, frames_sent, starts_taken, starts_refused, ticks_seen;

    function new(int unsigned nbits);
      frame_bits  = nbits;
      bit_slots   = BitSlotsRst;
      second_slot = SecondSlotRst;
      eos_slots   = EosSlotsRst;
      latch_slots = LatchSlotsRst;
      shift_word  = '0;
      bits_left   = '0;
      slot_cnt    = '0;
      line_phase  = LineIdle;
    endfunction

    function void set_reg(logic [CfgAddrW-1:0] idx, logic [SlotW-1:0] val);
      case (idx)
        CfgBitSlots:   bit_slots   = val;
        CfgSecondSlot: second_slot = val;
        CfgEosSlots:   eos_slots   = val;
        default:       latch_slots = val;
      endcase
    endfunction

    // Advance the slot counter; a zero length behaves as one.
    function bit slot_done(logic [SlotW-1:0] len);
      slot_cnt = slot_cnt + 1'b1;
      if (slot_cnt >= len || slot_cnt == 0) begin
        slot_cnt = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(logic kind, logic [7:0] red, logic [7:0] green, logic [7:0] blue);
      res_t want;
      logic msb;
      want = '0;
      if (kind == KindStart) begin
        want.busy_res = 1'b1;
        if (line_phase == LineIdle) begin
          shift_word = {HeaderByte, red, green, blue};
          bits_left  = CountW'(frame_bits);
          slot_cnt   = '0;
          line_phase = (bits_left == 0) ? LineEos : LineData;
          want.accepted = 1'b1;
          starts_taken++;
        end else begin
          starts_refused++;
        end
      end else begin
        ticks_seen++;
        case (line_phase)
          LineData: begin
            msb = shift_word[WordW-1];
            want.busy_res   = 1'b1;
            want.line_level = (slot_cnt == 0) || (msb && slot_cnt == second_slot);
            if (slot_done(bit_slots)) begin
              shift_word = shift_word << 1;
              bits_left  = bits_left - 1'b1;
              if (bits_left == 0) line_phase = LineEos;
            end
          end
          LineEos: begin
            want.busy_res = 1'b1;
            if (slot_done(eos_slots)) line_phase = LineLatch;
          end
          LineLatch: begin
            want.busy_res = 1'b1;
            if (slot_done(latch_slots)) begin
              line_phase      = LineIdle;
              want.frame_done = 1'b1;
              frames_sent++;
            end
          end
          default: ;
        endcase
      end
      line_results_q.push_back(want);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (line_results_q.size() == 0) begin
        $error("unexpected result transfer: %b", got);
        errors++;
        return;
      end
      want = line_results_q.pop_front();
      if (got.line_level !== want.line_level) begin
        $error("line_level: expected %0b, got %0b", want.line_level, got.line_level);
        errors++;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
        errors++;
      end
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
        errors++;
      end
    endfunction

    function int pending();
      return line_results_q.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata  = '0;
  logic                s_axis_tuser  = KindTick;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_we_i      = 1'b0;
  logic [CfgAddrW-1:0] cfg_addr_i    = CfgBitSlots;
  logic [SlotW-1:0]    cfg_wdata_i   = '0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_flip      = 1'b0;
  logic hold_seen      = 1'b0;
  int   hold_left      = 0;

  frame_scoreboard sb;

  single_wire_led_frame_sender #(
    .FRAME_BITS(FrameBits)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: check every transfer, then decide ready for the next edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result('{line_level: m_axis_tdata[0], busy_res: m_axis_tdata[1],
                        accepted: m_axis_tdata[2], frame_done: m_axis_tlast});
    end
    if (hold_flip != hold_seen) begin
      hold_seen     <= hold_flip;
      hold_left     <= HoldCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_mode(input int mode);
    case (mode % 4)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
      default: begin send_idle_pct = 10; recv_stall_pct = 10; end
    endcase
  endtask

  // Offer one item; optionally hold off first until every result is back.
  task automatic send_item(input logic kind, input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue, input bit settle);
    if (settle || ($urandom_range(99) < send_idle_pct)) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i);
      while ((settle && sb.pending() != 0) || ($urandom_range(99) < send_idle_pct));
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {blue, green, red};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(kind, red, green, blue);
  endtask

  task automatic settle_line();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [SlotW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic write_cfg(input logic [7:0] slots, input logic [7:0] pulse,
                           input logic [7:0] eos, input logic [7:0] latch);
    write_reg(CfgBitSlots, slots);
    write_reg(CfgSecondSlot, pulse);
    write_reg(CfgEosSlots, eos);
    write_reg(CfgLatchSlots, latch);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_frame();
    while (sb.line_phase != LineIdle)
      send_item(KindTick, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
  endtask

  // A frame in progress carries over into the next settings.
  task automatic run_phase(input logic [7:0] slots, input logic [7:0] pulse,
                           input logic [7:0] eos, input logic [7:0] latch,
                           input int n_items, input int mode);
    logic kind;
    settle_line();
    write_cfg(slots, pulse, eos, latch);
    set_mode(mode);
    for (int i = 0; i < n_items; i++) begin
      kind = ($urandom_range(11) == 0) ? KindStart : KindTick;
      // stall the result side for a while so the block backs up into the input
      if (i == n_items / 4) hold_flip <= ~hold_flip;
      send_item(kind, 8'($urandom), 8'($urandom), 8'($urandom), i == n_items / 2);
    end
  endtask

  initial begin
    logic [7:0] slots;
    sb = new(FrameBits);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: tick while idle, a taken start, a refused start, part of a frame.
    set_mode(0);
    send_item(KindTick, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_item(KindStart, 8'hFF, 8'h00, 8'hA5, 1'b0);
    send_item(KindStart, 8'h00, 8'hFF, 8'h5A, 1'b0);
    repeat (16) send_item(KindTick, 8'h00, 8'h00, 8'h00, 1'b0);

    run_phase(8'd4, 8'd2, 8'd1, 8'd1, 30, 0);
    run_phase(8'd4, 8'd3, 8'd1, 8'd1, 30, 1);
    // zero periods act as one; second pulse at zero merges with the opening pulse
    run_phase(8'd0, 8'd0, 8'd0, 8'd0, 30, 2);
    // second pulse beyond or at the bit length never shows
    run_phase(8'd1, 8'd5, 8'd1, 8'd1, 20, 3);
    run_phase(8'd6, 8'd6, 8'd3, 8'd2, 20, 0);
    for (int k = 0; k < 4; k++) begin
      slots = 8'($urandom_range(10, 4));
      run_phase(slots, 8'($urandom_range(slots + 1, 0)), 8'($urandom_range(12, 1)),
                8'($urandom_range(12, 1)), 25, k);
    end

    // Finish the running frame quickly before the long-period frame.
    settle_line();
    write_cfg(8'd1, 8'd0, 8'd1, 8'd1);
    drain_frame();

    // Longest periods: start a frame, then shorten every period mid-frame while
    // the slot counter sits far past the new bit length.
    settle_line();
    write_cfg(8'd255, 8'd253, 8'd255, 8'd255);
    set_mode(3);
    send_item(KindStart, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    repeat (40) send_item(KindTick, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
    settle_line();
    write_cfg(8'd4, 8'd2, 8'd1, 8'd1);
    drain_frame();

    settle_line();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d ticks and %0d starts (%0d refused while busy); %0d frames completed",
             sb.ticks_seen, sb.starts_taken + sb.starts_refused, sb.starts_refused,
             sb.frames_sent);
    $display("Timing registers set from zero to 255, also changed mid-frame, under four pacing modes");
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/slfs_pkg.sv
rtl/slfs_cfg_regs.sv
rtl/slfs_engine.sv
rtl/single_wire_led_frame_sender.sv
tb/sv/tb_single_wire_led_frame_sender.sv
